[sv/tdaf_pkg.sv]
// Shared types, constants and arithmetic helpers for the two-degree-of-freedom
// anti-windup force controller. No dependencies.
package tdaf_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] REG_PREFILTER_DEN = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PREFILTER_NUM = 3'd1;
  localparam logic [CFG_AW-1:0] REG_LOOP_DEN      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_LOOP_NUM      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_LOOP_GAIN     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_FORCE_LIMITS  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_DEAD_BAND     = 3'd6;
  localparam logic [CFG_AW-1:0] REG_FORCE_OFFSET  = 3'd7;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] drive_force;
    logic               in_dead_band;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
    logic               dead;
  } qitem_t;

  typedef struct packed {
    logic [63:0]        prefilter_den;
    logic [63:0]        prefilter_num;
    logic [63:0]        loop_den;
    logic [63:0]        loop_num;
    logic signed [31:0] loop_gain;
    logic [63:0]        force_limits;
    logic [30:0]        dead_band;
    logic signed [31:0] force_offset;
  } cfg_t;

  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qhead_t;

  localparam logic signed [48:0] SAT_MAX = 49'sd2147483647;
  localparam logic signed [48:0] SAT_MIN = -49'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (x < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0]        s;
    logic signed [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] round_sat28(input logic signed [63:0] x);
    logic signed [35:0] q;
    logic signed [48:0] r;
    q = x[63:28];
    r = 49'(q) + {48'd0, x[27]};
    return sat32(r);
  endfunction

  function automatic logic signed [31:0] round_sat16(input logic signed [63:0] x);
    logic signed [47:0] q;
    logic signed [48:0] r;
    q = x[63:16];
    r = 49'(q) + {48'd0, x[15]};
    return sat32(r);
  endfunction

endpackage

[sv/tdaf_queue.sv]
// Two-entry flip-flop queue between the classifier and the arithmetic sequencer.
// Depends on tdaf_pkg.
module tdaf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tdaf_pkg::qitem_t push_item,
  output logic            full,
  input  logic            pop,
  output tdaf_pkg::qhead_t head
);
  import tdaf_pkg::*;

  qitem_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full       = (count == (QAW+1)'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

[sv/tdaf_front.sv]
// Sample intake: accepts a sample, classifies it against the dead band and
// queues it for the sequencer. Depends on tdaf_pkg and tdaf_queue.
module tdaf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  tdaf_pkg::sample_t sample,
  input  logic [30:0]       dead_band,
  input  logic              pop,
  output tdaf_pkg::qhead_t  head
);
  import tdaf_pkg::*;

  logic               full;
  logic               push;
  logic signed [32:0] err;
  logic signed [32:0] db;
  qitem_t             item;

  assign err  = 33'(sample.setpoint) - 33'(sample.measured);
  assign db   = {2'b00, dead_band};

  assign item.setpoint = sample.setpoint;
  assign item.measured = sample.measured;
  assign item.dead     = (err < db) && (err > -db);

  assign sample_stall = full;
  assign push         = sample_valid && !full;

  tdaf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (item),
    .full      (full),
    .pop       (pop),
    .head      (head)
  );

endmodule

[sv/tdaf_back.sv]
// Arithmetic sequencer: one shared 32x32 multiplier and a saturating 64-bit
// accumulator run both filters, the gain, clamp and offset. Depends on tdaf_pkg.
module tdaf_back (
  input  logic             clk,
  input  logic             rst,
  input  tdaf_pkg::cfg_t   cfg,
  input  tdaf_pkg::qhead_t head,
  output logic             pop,
  output logic             cmd_valid,
  input  logic             cmd_stall,
  output tdaf_pkg::cmd_t   cmd
);
  import tdaf_pkg::*;

  localparam logic [3:0] ST_P0     = 4'd0;
  localparam logic [3:0] ST_P1     = 4'd1;
  localparam logic [3:0] ST_P2     = 4'd2;
  localparam logic [3:0] ST_P3     = 4'd3;
  localparam logic [3:0] ST_PACC   = 4'd4;
  localparam logic [3:0] ST_W0     = 4'd5;
  localparam logic [3:0] ST_W1     = 4'd6;
  localparam logic [3:0] ST_W2     = 4'd7;
  localparam logic [3:0] ST_W3     = 4'd8;
  localparam logic [3:0] ST_WACC   = 4'd9;
  localparam logic [3:0] ST_WROUND = 4'd10;
  localparam logic [3:0] ST_CORR   = 4'd11;
  localparam logic [3:0] ST_GAIN   = 4'd12;
  localparam logic [3:0] ST_GROUND = 4'd13;
  localparam logic [3:0] ST_CLAMP  = 4'd14;
  localparam logic [3:0] ST_OUT    = 4'd15;

  logic               busy;
  logic [3:0]         step;
  logic signed [31:0] sp;
  logic signed [31:0] meas;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic signed [31:0] pre;
  logic signed [31:0] wind;
  logic signed [31:0] corr;
  logic signed [31:0] frc;
  logic signed [31:0] pre_lag1, pre_lag2;
  logic signed [31:0] sp_lag1, sp_lag2;
  logic signed [31:0] wind_lag1, wind_lag2;
  logic signed [31:0] cf_lag1, cf_lag2;

  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] fmin, fmax, clamped;
  logic signed [33:0] corr_full;
  logic signed [32:0] offset_sum;
  logic               out_free;
  logic               load_dead;
  logic               load_live;
  logic               finish;

  assign fmin = cfg.force_limits[31:0];
  assign fmax = cfg.force_limits[63:32];

  always_comb begin
    unique case (step)
      ST_P0:   begin mul_a = cfg.prefilter_den[31:0];  mul_b = pre_lag1;  end
      ST_P1:   begin mul_a = cfg.prefilter_den[63:32]; mul_b = pre_lag2;  end
      ST_P2:   begin mul_a = cfg.prefilter_num[31:0];  mul_b = sp_lag1;   end
      ST_P3:   begin mul_a = cfg.prefilter_num[63:32]; mul_b = sp_lag2;   end
      ST_W0:   begin mul_a = cfg.loop_den[31:0];       mul_b = wind_lag1; end
      ST_W1:   begin mul_a = cfg.loop_den[63:32];      mul_b = wind_lag2; end
      ST_W2:   begin mul_a = cfg.loop_num[31:0];       mul_b = cf_lag1;   end
      ST_W3:   begin mul_a = cfg.loop_num[63:32];      mul_b = cf_lag2;   end
      default: begin mul_a = corr;                     mul_b = cfg.loop_gain; end
    endcase
  end

  always_comb begin
    priority if (frc > fmax) begin
      clamped = fmax;
    end else if (frc < fmin) begin
      clamped = fmin;
    end else begin
      clamped = frc;
    end
  end

  assign corr_full  = 34'(pre) - 34'(meas) - 34'(wind);
  assign offset_sum = 33'(frc) + 33'(cfg.force_offset);

  assign out_free  = !cmd_valid || !cmd_stall;
  assign load_dead = !busy && head.valid && head.item.dead && out_free;
  assign load_live = !busy && head.valid && !head.item.dead;
  assign finish    = busy && (step == ST_OUT) && out_free;
  assign pop       = load_dead || load_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= ST_P0;
      cmd_valid <= 1'b0;
      pre_lag1  <= '0;
      pre_lag2  <= '0;
      sp_lag1   <= '0;
      sp_lag2   <= '0;
      wind_lag1 <= '0;
      wind_lag2 <= '0;
      cf_lag1   <= '0;
      cf_lag2   <= '0;
    end else begin
      if (load_dead || finish) begin
        cmd_valid <= 1'b1;
      end else if (!cmd_stall) begin
        cmd_valid <= 1'b0;
      end
      if (load_live) begin
        busy <= 1'b1;
        step <= ST_P0;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (busy && step != ST_OUT) begin
        step <= step + 1'b1;
      end
      if (busy && step == ST_CLAMP) begin
        pre_lag2  <= pre_lag1;
        pre_lag1  <= pre;
        sp_lag2   <= sp_lag1;
        sp_lag1   <= sp;
        wind_lag2 <= wind_lag1;
        wind_lag1 <= wind;
        cf_lag2   <= cf_lag1;
        cf_lag1   <= clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    if (load_live) begin
      sp   <= head.item.setpoint;
      meas <= head.item.measured;
    end
    if (load_dead) begin
      cmd.drive_force  <= '0;
      cmd.in_dead_band <= 1'b1;
    end else if (finish) begin
      cmd.drive_force  <= sat32(49'(offset_sum));
      cmd.in_dead_band <= 1'b0;
    end
    if (busy) begin
      unique case (step)
        ST_P0: acc <= '0;
        ST_P1, ST_P2, ST_P3, ST_PACC, ST_W1, ST_W2, ST_W3, ST_WACC:
          acc <= sat_add64(acc, prod);
        ST_W0: begin
          pre <= round_sat28(acc);
          acc <= '0;
        end
        ST_WROUND: wind <= round_sat28(acc);
        ST_CORR:   corr <= sat32(49'(corr_full));
        ST_GROUND: frc  <= round_sat16(prod);
        ST_CLAMP:  frc  <= clamped;
        default:   acc  <= acc;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd.in_dead_band |-> cmd.drive_force == '0)
    else $error("dead-band result carries nonzero force");
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(busy && step == ST_CLAMP) |=> $stable(cf_lag1) && $stable(sp_lag1))
    else $error("filter state changed outside update step");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pop) else $error("queue popped while sequencer busy");
  a_finish_step: assert property (@(posedge clk) disable iff (rst)
    finish |=> !busy && cmd_valid) else $error("finished item not presented");
`endif

endmodule

[sv/two_dof_antiwindup_force_controller.sv]
// Top level of the two-degree-of-freedom anti-windup force controller (pitch axis).
// Holds the configuration registers; depends on tdaf_pkg, tdaf_front, tdaf_back.
//
// Usage:
//   sample channel: sample_valid / sample_stall / sample (setpoint, measured).
//     A sample transfers on a clock edge with sample_valid high and sample_stall low.
//   cmd channel: cmd_valid / cmd_stall / cmd (drive_force, in_dead_band).
//     A result transfers on a clock edge with cmd_valid high and cmd_stall low.
//   cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is always
//     high. Write only while no sample is in flight.
// Timing: a two-entry queue decouples intake from the sequencer. A dead-band
//   sample is popped from the queue straight into the output register with zero
//   force and never makes the sequencer busy. Any other sample occupies the shared
//   32x32 multiplier and 64-bit accumulator (eight filter products, gain product,
//   rounding, clamp, offset); the sequencer takes the next queued sample only
//   once this result has been loaded into the output register.
// Reset (rst, synchronous): clears registers, filter history, queue and cmd_valid.
// Stall: a held result blocks the sequencer only when it must present the next
//   result; intake continues until the queue fills, then sample_stall rises.
module two_dof_antiwindup_force_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  tdaf_pkg::sample_t             sample,
  output logic                          cmd_valid,
  input  logic                          cmd_stall,
  output tdaf_pkg::cmd_t                cmd,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tdaf_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [63:0]                   cfg_data
);
  import tdaf_pkg::*;

  cfg_t   cfg;
  qhead_t head;
  logic   pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PREFILTER_DEN: cfg.prefilter_den <= cfg_data;
        REG_PREFILTER_NUM: cfg.prefilter_num <= cfg_data;
        REG_LOOP_DEN:      cfg.loop_den      <= cfg_data;
        REG_LOOP_NUM:      cfg.loop_num      <= cfg_data;
        REG_LOOP_GAIN:     cfg.loop_gain     <= cfg_data[31:0];
        REG_FORCE_LIMITS:  cfg.force_limits  <= cfg_data;
        REG_DEAD_BAND:     cfg.dead_band     <= cfg_data[30:0];
        REG_FORCE_OFFSET:  cfg.force_offset  <= cfg_data[31:0];
        default:           cfg               <= cfg;
      endcase
    end
  end

  tdaf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .dead_band    (cfg.dead_band),
    .pop          (pop),
    .head         (head)
  );

  tdaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd)
  );

endmodule
